/* rtl/lss_pkg.sv */
// Shared types and constants for the LIFO stack with search.
// No dependencies; every other file in rtl/ imports this package.
package lss_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OCC_W     = 5;

  typedef enum logic [1:0] {
    FN_PUSH   = 2'd0,
    FN_POP    = 2'd1,
    FN_PEEK   = 2'd2,
    FN_SEARCH = 2'd3
  } func_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [WORD_W-1:0] NONE_WORD = '1;

  // Which value and status the datapath loads into the result registers.
  typedef enum logic [2:0] {
    RES_PUSH_OK    = 3'd0,
    RES_FULL       = 3'd1,
    RES_POP_EMPTY  = 3'd2,
    RES_PEEK_EMPTY = 3'd3,
    RES_WORD       = 3'd4,
    RES_FOUND      = 3'd5,
    RES_NOTFOUND   = 3'd6
  } res_sel_t;

  typedef struct packed {
    logic     latch;      // capture func and operand
    logic     wr;         // write operand at the top and grow the stack
    logic     dec;        // shrink the stack by one
    logic     rd_top;     // read the top entry and start a walk there
    logic     scan_step;  // move the walk one entry down
    logic     finish;     // load the result registers
    res_sel_t sel;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  empty;
    logic  full;
    logic  match;  // word read from memory equals the operand
    logic  last;   // walk sits on the bottom entry
  } sts_t;

endpackage

/* rtl/lss_dpath.sv */
// Datapath of the LIFO stack: entry memory, fill count, walk pointer and
// result registers. Depends on lss_pkg.
module lss_dpath #(
  parameter int unsigned DEPTH = lss_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lss_pkg::cmd_t                  cmd,
  input  logic [1:0]                     func,
  input  logic signed [lss_pkg::WORD_W-1:0] operand,
  output lss_pkg::sts_t                  sts,
  output logic signed [lss_pkg::WORD_W-1:0] data,
  output logic [1:0]                     status,
  output logic [lss_pkg::OCC_W-1:0]      occupancy,
  output logic                           nonempty
);
  import lss_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;

  func_t             func_q;
  logic [WORD_W-1:0] operand_q;
  logic [CW-1:0]     depth;
  logic [CW-1:0]     depth_m1;
  logic [AW-1:0]     top_addr;
  logic [AW-1:0]     addr_q;
  logic [AW-1:0]     idx;
  logic [CW+OCC_W-1:0] occ_ext;

  assign depth_m1 = depth - CW'(1);
  assign top_addr = depth_m1[AW-1:0];
  assign rd_addr  = cmd.rd_top ? top_addr : addr_q - AW'(1);
  assign rd_en    = cmd.rd_top | cmd.scan_step;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[depth[AW-1:0]] <= operand_q;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.wr) begin
      depth <= depth + CW'(1);
    end else if (cmd.dec) begin
      depth <= depth_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q    <= func_t'(func);
      operand_q <= operand;
    end
    if (cmd.rd_top) begin
      addr_q <= top_addr;
      idx    <= '0;
    end else if (cmd.scan_step) begin
      addr_q <= addr_q - AW'(1);
      idx    <= idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (cmd.sel)
        RES_PUSH_OK: begin
          data   <= '0;
          status <= ST_OK;
        end
        RES_FULL: begin
          data   <= '0;
          status <= ST_FULL;
        end
        RES_POP_EMPTY: begin
          data   <= NONE_WORD;
          status <= ST_EMPTY;
        end
        RES_PEEK_EMPTY: begin
          data   <= '0;
          status <= ST_EMPTY;
        end
        RES_WORD: begin
          data   <= rd_data;
          status <= ST_OK;
        end
        RES_FOUND: begin
          data   <= {{(WORD_W-AW){1'b0}}, idx};
          status <= ST_OK;
        end
        default: begin
          data   <= NONE_WORD;
          status <= ST_NOTFOUND;
        end
      endcase
    end
  end

  assign sts.func  = func_q;
  assign sts.empty = (depth == '0);
  assign sts.full  = (depth == CW'(DEPTH));
  assign sts.match = (rd_data == operand_q);
  assign sts.last  = (addr_q == '0);

  // Occupancy is the fill count cut to five bits.
  assign occ_ext   = {{OCC_W{1'b0}}, depth};
  assign occupancy = occ_ext[OCC_W-1:0];
  assign nonempty  = (depth != '0);

endmodule

/* rtl/lss_ctrl.sv */
// Controller state machine of the LIFO stack; issues datapath commands.
// Depends on lss_pkg.
module lss_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  lss_pkg::sts_t sts,
  output lss_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);
  import lss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_RESP = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.sel    = RES_PUSH_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.func)
          FN_PUSH: begin
            cmd.finish = 1'b1;
            cmd.wr     = !sts.full;
            cmd.sel    = sts.full ? RES_FULL : RES_PUSH_OK;
            state_next = S_IDLE;
          end
          FN_POP: begin
            if (sts.empty) begin
              cmd.finish = 1'b1;
              cmd.sel    = RES_POP_EMPTY;
              state_next = S_IDLE;
            end else begin
              cmd.rd_top = 1'b1;
              cmd.dec    = 1'b1;
              state_next = S_RESP;
            end
          end
          FN_PEEK: begin
            if (sts.empty) begin
              cmd.finish = 1'b1;
              cmd.sel    = RES_PEEK_EMPTY;
              state_next = S_IDLE;
            end else begin
              cmd.rd_top = 1'b1;
              state_next = S_RESP;
            end
          end
          default: begin
            if (sts.empty) begin
              cmd.finish = 1'b1;
              cmd.sel    = RES_NOTFOUND;
              state_next = S_IDLE;
            end else begin
              cmd.rd_top = 1'b1;
              state_next = S_SCAN;
            end
          end
        endcase
      end
      S_RESP: begin
        cmd.finish = 1'b1;
        cmd.sel    = RES_WORD;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (sts.match) begin
          cmd.finish = 1'b1;
          cmd.sel    = RES_FOUND;
          state_next = S_IDLE;
        end else if (sts.last) begin
          cmd.finish = 1'b1;
          cmd.sel    = RES_NOTFOUND;
          state_next = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* rtl/lifo_stack_with_search_core.sv */
// Top level of the LIFO stack with search: controller plus datapath.
// Depends on lss_pkg, lss_ctrl and lss_dpath.
//
// A fixed-depth LIFO stack of signed 32-bit words. A transaction is taken
// at the rising edge where start is high and busy is low; it carries an
// operation in func (push, pop, peek or search) and a word in operand.
// Every transaction gives exactly one result, shown for one cycle with
// done high; the receiver cannot stall it, so it must take data, status,
// occupancy and nonempty in that cycle. Push, and any operation on an
// empty stack, finish straight from the execute state; pop and peek
// pass through a response state because the entry memory has a
// registered read port; a search walks down from the top entry until
// the word matches or the bottom entry has been read, so a miss reads
// every held entry. The search speed is set by that single memory read
// port, which yields one entry per cycle. busy drops during the done
// cycle, so the next transaction can be accepted at the edge that ends
// it. Stored words are not cleared by reset; only the fill count is, and
// reads never reach an entry above it.
module lifo_stack_with_search_core #(
  parameter int unsigned DEPTH = lss_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        func,
  input  logic signed [lss_pkg::WORD_W-1:0] operand,
  output logic                              done,
  output logic signed [lss_pkg::WORD_W-1:0] data,
  output logic [1:0]                        status,
  output logic [lss_pkg::OCC_W-1:0]         occupancy,
  output logic                              nonempty
);
  import lss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each transaction; the datapath owns all storage.
  lss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  lss_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .func      (func),
    .operand   (operand),
    .sts       (sts),
    .data      (data),
    .status    (status),
    .occupancy (occupancy),
    .nonempty  (nonempty)
  );

  // A result always comes out with the controller back in idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while controller busy");

  // An accepted transaction keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start work");

  // A refused push is only reported when the stack is truly full.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> sts.full)
    else $error("full status with room left");

  // An empty status must agree with the fill count.
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> !nonempty)
    else $error("empty status on a non-empty stack");

endmodule

/* dv/lss_tb_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the LIFO stack with search: a predictor of the stack plus a queue of results.
// Depends on lss_pkg for widths, operation codes and status codes.
package lss_tb_pkg;
  import lss_pkg::*;

  typedef struct {
    logic signed [WORD_W-1:0] data;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
    logic                     nonempty;
  } stack_result_t;

  class stack_scoreboard;
    logic signed [WORD_W-1:0] words[DEPTH_DEF];
    int unsigned              fill;
    int unsigned              errors;
    stack_result_t            pending_results[$];

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    // Apply one accepted transaction to the stack copy and queue its result.
    function void note(func_t fn, logic signed [WORD_W-1:0] word);
      stack_result_t r;
      int unsigned   i;
      bit            found;
      r.data   = '0;
      r.status = ST_OK;
      found    = 1'b0;
      case (fn)
        FN_PUSH: begin
          if (fill >= DEPTH_DEF) begin
            r.status = ST_FULL;
          end else begin
            words[fill] = word;
            fill++;
          end
        end
        FN_POP: begin
          if (fill == 0) begin
            r.data   = NONE_WORD;
            r.status = ST_EMPTY;
          end else begin
            fill--;
            r.data = words[fill];
          end
        end
        FN_PEEK: begin
          if (fill == 0) r.status = ST_EMPTY;
          else r.data = words[fill-1];
        end
        default: begin
          r.data   = NONE_WORD;
          r.status = ST_NOTFOUND;
          for (i = 0; i < fill; i++) begin
            if (!found && words[fill-1-i] == word) begin
              r.data   = i;
              r.status = ST_OK;
              found    = 1'b1;
            end
          end
        end
      endcase
      r.occupancy = fill[OCC_W-1:0];
      r.nonempty  = (fill != 0);
      pending_results.push_back(r);
    endfunction

    // Compare one result from the block with the oldest queued one.
    function void check(logic signed [WORD_W-1:0] d, logic [1:0] s,
                        logic [OCC_W-1:0] o, logic ne);
      stack_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing queued: data %0d status %0d", $time, d, s);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (d !== want.data) begin
        $display("%0t: data expected %0d actual %0d", $time, want.data, d);
        errors++;
      end
      if (s !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, s);
        errors++;
      end
      if (o !== want.occupancy) begin
        $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy, o);
        errors++;
      end
      if (ne !== want.nonempty) begin
        $display("%0t: nonempty expected %0b actual %0b", $time, want.nonempty, ne);
        errors++;
      end
    endfunction

    // Anything still queued at the end is a missing result.
    function void close_out();
      if (pending_results.size() != 0) begin
        $display("%0t: %0d results never arrived", $time, pending_results.size());
        errors += pending_results.size();
      end
    endfunction
  endclass

endpackage

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Top-level testbench for lifo_stack_with_search_core: clock, reset, stimulus and monitor.
// Depends on lss_pkg, lss_tb_pkg and the RTL of the stack.
module testbench;
  import lss_pkg::*;
  import lss_tb_pkg::*;

  // About 1700 random transactions follow the directed ones. The slowest
  // transaction is a search with no match on a full stack, and the sender
  // gaps are bounded by the idle task, so the limit below is several times
  // the slowest correct run.
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               func;
  logic signed [WORD_W-1:0] operand;
  logic                     done;
  logic signed [WORD_W-1:0] data;
  logic [1:0]               status;
  logic [OCC_W-1:0]         occupancy;
  logic                     nonempty;

  stack_scoreboard board;
  int unsigned     cycles;

  lifo_stack_with_search_core uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .operand   (operand),
    .done      (done),
    .data      (data),
    .status    (status),
    .occupancy (occupancy),
    .nonempty  (nonempty)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // The monitor samples at the rising edge. A result is checked before the
  // transaction taken at the same edge is noted, since the result always
  // belongs to an earlier transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check(data, status, occupancy, nonempty);
      if (start && !busy) board.note(func_t'(func), operand);
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one transaction at the falling edge and hold it until the
  // rising edge where busy is low takes it. start is left high, so a
  // following send keeps it high with a single assignment per time step.
  task automatic send(input func_t fn, input logic signed [WORD_W-1:0] word);
    @(negedge clk);
    start   <= 1'b1;
    func    <= fn;
    operand <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Sender gap with start low; n sets its length.
  task automatic idle(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Hold off new transactions until every queued result has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // Words for pushes: mostly full-range random, with a small pool that
  // makes duplicates likely and the extremes of the signed range.
  function automatic logic signed [WORD_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom;
    if (r < 8) return $urandom_range(0, 7);
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  // Search words: usually one that is held somewhere in the stack, so that
  // hits land at every distance; otherwise anything, which mostly misses.
  function automatic logic signed [WORD_W-1:0] pick_target();
    if (board.fill != 0 && $urandom_range(0, 3) != 0)
      return board.words[$urandom_range(0, board.fill - 1)];
    return pick_word();
  endfunction

  // Directed part: every operation on an empty stack, a fill to the brim
  // with the extreme words and a duplicate, a refused push, searches that
  // hit the bottom entry, pick the upper of two equal words and miss.
  task automatic directed_phase();
    int unsigned i;
    send(FN_PEEK, 32'sd0);
    send(FN_POP, 32'sd0);
    send(FN_SEARCH, 32'sd0);
    send(FN_PUSH, 32'sh8000_0000);
    send(FN_PUSH, 32'sh7fff_ffff);
    send(FN_PUSH, -32'sd1);
    send(FN_PUSH, 32'sd0);
    send(FN_PUSH, 32'sd5);
    send(FN_PUSH, 32'shaaaa_aaaa);
    send(FN_PUSH, 32'sh5555_5555);
    for (i = 7; i < DEPTH_DEF - 1; i++) send(FN_PUSH, 32'sd100 + i);
    send(FN_PUSH, 32'sd5);
    send(FN_PUSH, 32'sd1234);
    send(FN_SEARCH, 32'sh8000_0000);
    send(FN_SEARCH, 32'sd5);
    send(FN_SEARCH, 32'sd999);
    send(FN_PEEK, 32'sd0);
    send(FN_POP, 32'sd0);
  endtask

  // Random part. The share of pushes is redrawn as high or low every 40
  // transactions so the stack swings between full and empty.
  task automatic random_phase();
    int unsigned sent;
    int unsigned burst;
    int unsigned k;
    int unsigned push_pct;
    func_t       fn;
    sent     = 0;
    push_pct = 70;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 99) < push_pct) fn = FN_PUSH;
        else fn = func_t'($urandom_range(1, 3));
        if (fn == FN_SEARCH) send(fn, pick_target());
        else if (fn == FN_PUSH) send(fn, pick_word());
        else send(fn, $urandom);
        sent++;
        if (sent % 40 == 0) push_pct = ($urandom_range(0, 1) != 0) ? 75 : 20;
      end
      if ($urandom_range(0, 50) == 0) drain();
      else if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
    end
  endtask

  initial begin
    board   = new();
    rst     = 1'b1;
    start   = 1'b0;
    func    = FN_PUSH;
    operand = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_phase();
    drain();
    random_phase();

    // Wait out all results, then keep the clock running to catch any stray strobe.
    drain();
    repeat (DEPTH_DEF + 4) @(posedge clk);
    board.close_out();
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* lifo_stack_with_search_core.f */
rtl/lss_pkg.sv
rtl/lss_dpath.sv
rtl/lss_ctrl.sv
rtl/lifo_stack_with_search_core.sv
dv/lss_tb_pkg.sv
dv/testbench.sv
